// ===== rtl/mrrsa_pkg.sv =====
// Shared types and constants of the multi-reader ring space allocator.
package mrrsa_pkg;

  // Command codes on the request channel.
  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_REG    = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  // Ring capacity after reset, in bytes.
  localparam logic [31:0] CAP_RESET = 32'd1048576;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_LARGE  = 3'd1,
    ST_NO_SPACE   = 3'd2,
    ST_FULL       = 3'd3,
    ST_BAD_READER = 3'd4
  } status_e;

  // Operation after classification by the front end.
  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_TOO_LARGE,
    OP_REG,
    OP_UPDATE,
    OP_BAD_READER,
    OP_NOP
  } op_e;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_PREP,
    BK_COMMIT,
    BK_REPLY
  } back_state_e;

  // One classified request as it travels through the queue.
  typedef struct packed {
    op_e         op;
    logic [31:0] size;
    logic [2:0]  id;
    logic [47:0] pos;
  } req_t;

endpackage

// ===== rtl/mrrsa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mrrsa_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mrrsa_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end.
module mrrsa_front #(
  parameter int MAX_READERS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          cmd_i,
  input  logic [31:0]         request_size_i,
  input  logic [2:0]          reader_id_i,
  input  logic [47:0]         reader_position_i,
  input  logic [31:0]         cap_i,
  output logic                req_valid_o,
  output mrrsa_pkg::req_t     req_o,
  input  logic                req_pop_i
);
  import mrrsa_pkg::*;

  req_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  req_t       cls;

  // Classification: everything that is known at acceptance is decided here.
  always_comb begin
    cls.size = request_size_i;
    cls.id   = reader_id_i;
    cls.pos  = reader_position_i;
    unique case (cmd_i)
      CMD_ALLOC:  cls.op = (request_size_i > cap_i) ? OP_TOO_LARGE : OP_ALLOC;
      CMD_REG:    cls.op = OP_REG;
      CMD_UPDATE: cls.op = (32'(reader_id_i) >= 32'(MAX_READERS)) ? OP_BAD_READER
                                                                    : OP_UPDATE;
      CMD_NONE:   cls.op = OP_NOP;
      default:    cls.op = OP_NOP;
    endcase
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign req_valid_o = (cnt_q != 2'd0);
  assign req_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + push;
    rd_ptr_d = rd_ptr_q + req_pop_i;
    cnt_d    = cnt_q + 2'(push) - 2'(req_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ===== rtl/mrrsa_back.sv =====
// Back end: executes queued requests, scans readers and holds the result register.
module mrrsa_back #(
  parameter int MAX_READERS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  mrrsa_pkg::req_t req_i,
  output logic            req_pop_o,
  input  logic [31:0]     cap_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [2:0]      status_o,
  output logic [31:0]     block_offset_o,
  output logic [2:0]      assigned_reader_o
);
  import mrrsa_pkg::*;

  localparam int AW  = (MAX_READERS > 1) ? $clog2(MAX_READERS) : 1;
  localparam int CW  = $clog2(MAX_READERS + 1);
  localparam int IDW = (AW > 3) ? AW : 3;
  localparam int RW  = (CW > 3) ? CW : 3;

  back_state_e state_q, state_d;
  req_t        req_q, req_d;
  logic [47:0] wp_q, wp_d;
  logic [31:0] woff_q, woff_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] scan_idx_q, scan_idx_d;
  logic        have_q, have_d;
  logic        first_q, first_d;
  logic [47:0] min_q, min_d;
  logic [47:0] lag_q, lag_d;
  logic [32:0] adv_q, adv_d;
  logic [32:0] end_q, end_d;
  logic        fits_q, fits_d;
  logic        out_valid_q, out_valid_d;
  logic [2:0]  out_status_q, out_status_d;
  logic [31:0] out_offset_q, out_offset_d;
  logic [2:0]  out_assigned_q, out_assigned_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [47:0]   ram_wdata;
  logic [47:0]   ram_rdata;
  logic          res_ready;
  logic          issue;
  logic          cur_lt;
  logic [48:0]   need;
  logic [IDW-1:0] id_ext;
  logic [RW-1:0]  cnt_ext;

  mrrsa_ram #(
    .WIDTH (48),
    .DEPTH (MAX_READERS)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (scan_idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign res_ready = !out_valid_q || !out_stall_i;
  assign issue     = (scan_idx_q < count_q);
  assign cur_lt    = (woff_q < cap_i);
  assign need      = {1'b0, lag_q} + {16'd0, adv_q};
  assign id_ext    = IDW'(req_q.id);
  assign cnt_ext   = RW'(count_q);

  always_comb begin
    state_d        = state_q;
    req_d          = req_q;
    wp_d           = wp_q;
    woff_d         = woff_q;
    count_d        = count_q;
    scan_idx_d     = scan_idx_q;
    have_d         = have_q;
    first_d        = first_q;
    min_d          = min_q;
    lag_d          = lag_q;
    adv_d          = adv_q;
    end_d          = end_q;
    fits_d         = fits_q;
    out_valid_d    = out_valid_q && out_stall_i;
    out_status_d   = out_status_q;
    out_offset_d   = out_offset_q;
    out_assigned_d = out_assigned_q;
    req_pop_o      = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = count_q[AW-1:0];
    ram_wdata      = wp_q;

    unique case (state_q)
      BK_IDLE: begin
        if (req_valid_i) begin
          req_pop_o  = 1'b1;
          req_d      = req_i;
          scan_idx_d = '0;
          have_d     = 1'b0;
          first_d    = 1'b1;
          if (req_i.op == OP_ALLOC) begin
            if (count_q == '0) begin
              min_d   = wp_q;
              state_d = BK_PREP;
            end else begin
              state_d = BK_SCAN;
            end
          end else begin
            state_d = BK_REPLY;
          end
        end
      end

      BK_SCAN: begin
        // Reads are issued one per cycle; the read data comes back from the RAM's output register.
        if (have_q) begin
          if (first_q || (ram_rdata < min_q)) begin
            min_d = ram_rdata;
          end
          first_d = 1'b0;
        end
        have_d = issue;
        if (issue) begin
          scan_idx_d = scan_idx_q + 1'b1;
        end else begin
          state_d = BK_PREP;
        end
      end

      BK_PREP: begin
        lag_d  = wp_q - min_q;
        end_d  = {1'b0, woff_q} + {1'b0, req_q.size};
        fits_d = cur_lt && (end_d <= {1'b0, cap_i});
        if (fits_d) begin
          adv_d = {1'b0, req_q.size};
        end else if (cur_lt) begin
          adv_d = {1'b0, cap_i - woff_q} + {1'b0, req_q.size};
        end else begin
          adv_d = {1'b0, req_q.size};
        end
        state_d = BK_COMMIT;
      end

      BK_COMMIT: begin
        if (res_ready) begin
          out_valid_d    = 1'b1;
          out_offset_d   = '0;
          out_assigned_d = '0;
          if (need >= {17'd0, cap_i}) begin
            out_status_d = ST_NO_SPACE;
          end else begin
            out_status_d = ST_OK;
            if (fits_q) begin
              out_offset_d = woff_q;
              woff_d       = (end_q == {1'b0, cap_i}) ? 32'd0 : end_q[31:0];
            end else begin
              woff_d = req_q.size;
            end
            wp_d = wp_q + 48'(adv_q);
          end
          state_d = BK_IDLE;
        end
      end

      BK_REPLY: begin
        if (res_ready) begin
          out_valid_d    = 1'b1;
          out_offset_d   = '0;
          out_assigned_d = '0;
          out_status_d   = ST_OK;
          unique case (req_q.op)
            OP_REG: begin
              if (count_q >= CW'(MAX_READERS)) begin
                out_status_d = ST_FULL;
              end else begin
                ram_we         = 1'b1;
                ram_waddr      = count_q[AW-1:0];
                ram_wdata      = wp_q;
                out_assigned_d = cnt_ext[2:0];
                count_d        = count_q + 1'b1;
              end
            end
            OP_UPDATE: begin
              ram_we    = 1'b1;
              ram_waddr = id_ext[AW-1:0];
              ram_wdata = req_q.pos;
            end
            OP_BAD_READER: out_status_d = ST_BAD_READER;
            OP_TOO_LARGE:  out_status_d = ST_TOO_LARGE;
            OP_ALLOC,
            OP_NOP:        out_status_d = ST_OK;
            default:       out_status_d = ST_OK;
          endcase
          state_d = BK_IDLE;
        end
      end

      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      wp_q        <= '0;
      woff_q      <= '0;
      count_q     <= '0;
      scan_idx_q  <= '0;
      have_q      <= 1'b0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      woff_q      <= woff_d;
      count_q     <= count_d;
      scan_idx_q  <= scan_idx_d;
      have_q      <= have_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q          <= req_d;
    min_q          <= min_d;
    lag_q          <= lag_d;
    adv_q          <= adv_d;
    end_q          <= end_d;
    fits_q         <= fits_d;
    out_status_q   <= out_status_d;
    out_offset_q   <= out_offset_d;
    out_assigned_q <= out_assigned_d;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign block_offset_o    = out_offset_q;
  assign assigned_reader_o = out_assigned_q;

endmodule

// ===== rtl/multi_reader_ring_space_allocator.sv =====
// Top level of the multi-reader ring space allocator.
//
//  Channel   Direction  Handshake              Payload
//  request   in         in_valid_i/in_stall_o  cmd, request_size, reader_id, reader_position
//  result    out        out_valid_o/out_stall_i status, block_offset, assigned_reader
//  config    in         cfg_we_i               cfg_wdata_i (ring capacity)
//
// A register, update, unused, oversize or bad-reader request passes from idle
// through the reply state in the back end. An allocate request within the
// capacity passes through the scan, prep and commit states, or skips the scan
// with no reader registered; the reader position scan reads one entry of the
// position RAM per cycle. A stalled result holds the back end for as long as
// the stall lasts. Reset clears the write position, offset and reader count;
// the position RAM needs no clearing pass, since an entry is always written at
// registration before any scan reads it. Until full, a two-entry queue accepts
// requests while the back end works or a result waits in the output register.
module multi_reader_ring_space_allocator #(
  parameter int MAX_READERS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] request_size_i,
  input  logic [2:0]  reader_id_i,
  input  logic [47:0] reader_position_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] block_offset_o,
  output logic [2:0]  assigned_reader_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);
  import mrrsa_pkg::*;

  // The ring capacity register. The user must change it only while the block is
  // idle, so that both halves see one value; the block does not enforce this.
  logic [31:0] cap_q;
  logic        req_valid;
  logic        req_pop;
  req_t        req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // The front end decodes each request and flags oversize allocations and
  // bad reader identifiers before queueing it.
  mrrsa_front #(
    .MAX_READERS (MAX_READERS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .cmd_i             (cmd_i),
    .request_size_i    (request_size_i),
    .reader_id_i       (reader_id_i),
    .reader_position_i (reader_position_i),
    .cap_i             (cap_q),
    .req_valid_o       (req_valid),
    .req_o             (req),
    .req_pop_i         (req_pop)
  );

  // The back end owns the allocator state, finds the slowest reader and
  // commits each request together with its result.
  mrrsa_back #(
    .MAX_READERS (MAX_READERS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_valid_i       (req_valid),
    .req_i             (req),
    .req_pop_o         (req_pop),
    .cap_i             (cap_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .block_offset_o    (block_offset_o),
    .assigned_reader_o (assigned_reader_o)
  );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the multi-reader ring space allocator.
`timescale 1ns / 1ps

module testbench;
  import mrrsa_pkg::*;

  // Number of reader slots built into the block under test.
  localparam int MAX_RD = 8;
  // Length of the long receiver hold-off that fills the request queue.
  localparam int unsigned HOLD_CYCLES = 300;
  // Hard stop for the whole run, far beyond the slowest correct run.
  localparam int unsigned RUN_LIMIT_NS = 7_200_000;
  localparam int NUM_PHASES = 8;

  // One request as offered on the input channel.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] size;
    logic [2:0]  id;
    logic [47:0] pos;
  } alloc_req_t;

  // One reply as seen on the output channel.
  typedef struct packed {
    status_e     status;
    logic [31:0] offset;
    logic [2:0]  reader;
  } alloc_reply_t;

  // Everything the allocator remembers, plus its capacity register.
  typedef struct packed {
    logic [31:0]                  cap;
    logic [47:0]                  wpos;
    logic [31:0]                  woff;
    logic [3:0]                   nreaders;
    logic [MAX_RD-1:0][47:0]      rpos;
  } ring_state_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = CAP_RESET;
  alloc_req_t offered = '0;

  wire        in_stall_o;
  wire        out_valid_o;
  wire [2:0]  status_o;
  wire [31:0] block_offset_o;
  wire [2:0]  assigned_reader_o;
  wire [1:0]  cmd_i = offered.cmd;
  wire [31:0] request_size_i = offered.size;
  wire [2:0]  reader_id_i = offered.id;
  wire [47:0] reader_position_i = offered.pos;

  // Requests waiting to be offered, and replies predicted for accepted requests.
  alloc_req_t   queued_requests[$];
  alloc_reply_t pending_replies[$];

  // ring_now follows the requests the block has accepted; ring_plan runs ahead
  // at generation time so that stimulus can be shaped around the future state.
  ring_state_t ring_now;
  ring_state_t ring_plan;

  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        stall_hold_go = 1'b0;
  int unsigned stall_hold_left;

  multi_reader_ring_space_allocator #(
    .MAX_READERS(MAX_RD)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .request_size_i   (request_size_i),
    .reader_id_i      (reader_id_i),
    .reader_position_i(reader_position_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .block_offset_o   (block_offset_o),
    .assigned_reader_o(assigned_reader_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // Computes the reply to one request and advances the ring state. An allocate
  // is measured against the slowest registered reader, or against the writer
  // itself when no reader is registered. The grant must leave the writer
  // strictly less than one capacity ahead of that reader; a block that would
  // cross the end of the ring goes to offset zero and the tail is skipped.
  function automatic void predict_reply(inout ring_state_t s, input alloc_req_t r,
                                        output alloc_reply_t o);
    logic [47:0] low;
    logic [63:0] lag, adv, cur, cap;
    logic        fits;
    o.status = ST_OK;
    o.offset = '0;
    o.reader = '0;
    case (r.cmd)
      CMD_ALLOC: begin
        cap = {32'd0, s.cap};
        cur = {32'd0, s.woff};
        if (r.size > s.cap) begin
          o.status = ST_TOO_LARGE;
        end else begin
          low = s.wpos;
          for (int i = 0; i < MAX_RD; i++) begin
            if (i < s.nreaders && (i == 0 || s.rpos[i] < low)) low = s.rpos[i];
          end
          lag = {16'd0, s.wpos - low};
          fits = (cur < cap) && (cur + r.size <= cap);
          // A wrap also pays for the skipped tail; an offset left beyond a
          // lowered capacity has no tail to skip.
          adv = fits ? {32'd0, r.size} : ((cur < cap) ? cap - cur : 64'd0) + r.size;
          if (lag + adv >= cap) begin
            o.status = ST_NO_SPACE;
          end else begin
            if (fits) begin
              o.offset = s.woff;
              s.woff = (cur + r.size == cap) ? 32'd0 : s.woff + r.size;
            end else begin
              o.offset = '0;
              s.woff = r.size;
            end
            s.wpos = s.wpos + adv[47:0];
          end
        end
      end
      CMD_REG: begin
        if (s.nreaders >= MAX_RD) begin
          o.status = ST_FULL;
        end else begin
          // A new reader starts where the writer stands right now.
          s.rpos[s.nreaders[2:0]] = s.wpos;
          o.reader = s.nreaders[2:0];
          s.nreaders = s.nreaders + 4'd1;
        end
      end
      CMD_UPDATE: begin
        // Slots that are not registered yet still store the position.
        if ({29'd0, r.id} >= MAX_RD) o.status = ST_BAD_READER;
        else s.rpos[r.id] = r.pos;
      end
      default: begin
      end
    endcase
  endfunction

  // Queues one request and plays it on the look-ahead copy of the state.
  task automatic push_req(logic [1:0] cmd, logic [31:0] size, logic [2:0] id,
                          logic [47:0] pos);
    alloc_req_t   r;
    alloc_reply_t unused;
    r.cmd = cmd;
    r.size = size;
    r.id = id;
    r.pos = pos;
    predict_reply(ring_plan, r, unused);
    queued_requests.push_back(r);
  endtask

  // Moves every reader to within max_lag bytes behind the writer, which is
  // what lets allocations succeed again after the writer has run ahead.
  task automatic catch_up(logic [31:0] max_lag);
    for (int i = 0; i < MAX_RD; i++) begin
      push_req(CMD_UPDATE, $urandom(), 3'(i), ring_plan.wpos - $urandom_range(0, max_lag));
    end
  endtask

  // Directed opening run at the reset capacity, starting from an empty ring.
  task automatic push_directed();
    // Zero size, too large, a whole ring (one byte must stay free), one byte less,
    // then a block that ends exactly at the end so the offset returns to zero.
    push_req(CMD_ALLOC, 32'd0, 3'd0, 48'd0);
    push_req(CMD_ALLOC, CAP_RESET + 32'd1, 3'd0, 48'd0);
    push_req(CMD_ALLOC, CAP_RESET, 3'd0, 48'd0);
    push_req(CMD_ALLOC, CAP_RESET - 32'd1, 3'd0, 48'd0);
    push_req(CMD_ALLOC, 32'd1, 3'd0, 48'd0);
    // A half ring and a small block, then a second half that crosses the end
    // and wraps to zero, skipping the tail.
    push_req(CMD_ALLOC, CAP_RESET / 2, 3'd0, 48'd0);
    push_req(CMD_ALLOC, 32'd1000, 3'd0, 48'd0);
    push_req(CMD_ALLOC, CAP_RESET / 2, 3'd0, 48'd0);
    // An update of a slot that is not registered has no effect on allocation.
    push_req(CMD_UPDATE, 32'd0, 3'd5, 48'h0000_0000_0001);
    push_req(CMD_ALLOC, 32'd10, 3'd0, 48'd0);
    push_req(CMD_REG, 32'd0, 3'd0, 48'd0);
    // A reader set ahead of the writer looks hugely behind and blocks space.
    push_req(CMD_UPDATE, 32'd0, 3'd0, ring_plan.wpos + 48'd16);
    push_req(CMD_ALLOC, 32'd1, 3'd0, 48'd0);
    push_req(CMD_UPDATE, 32'd0, 3'd0, ring_plan.wpos);
    push_req(CMD_ALLOC, 32'd4, 3'd0, 48'd0);
    // The unused command with every field at its top value.
    push_req(CMD_NONE, 32'hFFFF_FFFF, 3'd7, 48'hFFFF_FFFF_FFFF);
    // Fill every reader slot, then one registration too many.
    for (int i = 1; i <= MAX_RD; i++) push_req(CMD_REG, 32'd0, 3'd0, 48'd0);
    push_req(CMD_UPDATE, 32'hFFFF_FFFF, 3'd7, 48'hFFFF_FFFF_FFFF);
  endtask

  // Random traffic. Most requests are allocations mixed with well-formed
  // position updates that trail the writer, so grants keep happening; the rest
  // are readers pushed ahead or to random places, registrations and the
  // unused command.
  task automatic push_random(int unsigned n);
    int unsigned roll;
    logic [31:0] cap, sz, lag;
    logic [63:0] wide;
    for (int unsigned k = 0; k < n; k++) begin
      cap = ring_plan.cap;
      wide = {$urandom(), $urandom()};
      roll = $urandom_range(0, 99);
      if (roll < 46) begin
        case ($urandom_range(0, 9))
          0: sz = wide[31:0];
          1: sz = cap + $urandom_range(0, 1);
          2: sz = cap - ring_plan.woff;
          default: sz = $urandom_range(0, cap / 16 + 1);
        endcase
        push_req(CMD_ALLOC, sz, wide[34:32], wide[63:16]);
      end else if (roll < 78) begin
        lag = ($urandom_range(0, 3) == 0) ? $urandom_range(0, cap) : $urandom_range(0, cap / 8);
        push_req(CMD_UPDATE, wide[31:0], 3'($urandom_range(0, 7)), ring_plan.wpos - lag);
      end else if (roll < 84) begin
        push_req(CMD_UPDATE, wide[31:0], wide[34:32],
                 wide[35] ? wide[47:0] : ring_plan.wpos + $urandom_range(1, 64));
      end else if (roll < 88) begin
        catch_up(cap / 32);
      end else if (roll < 94) begin
        push_req(CMD_REG, wide[31:0], wide[34:32], wide[63:16]);
      end else begin
        push_req(CMD_NONE, wide[31:0], wide[34:32], wide[63:16]);
      end
    end
  endtask

  // Returns once every queued request has been accepted and answered.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (queued_requests.size() != 0 || in_valid_i || pending_replies.size() != 0);
  endtask

  // Request driver. The accepted request is predicted at the edge that takes
  // it; a new request is offered only when the channel is free, so a stalled
  // payload never changes.
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_reply_t rep;
    logic         fire;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_reply(ring_now, offered, rep);
        pending_replies.push_back(rep);
      end
      if (!in_valid_i || !in_stall_o) begin
        fire = queued_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
        if (fire) offered <= queued_requests.pop_front();
        in_valid_i <= fire;
      end
    end
  end

  // Long receiver hold-off, counted here and started by a pulse from the
  // sequence below.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_hold_left <= 0;
    end else if (stall_hold_go) begin
      stall_hold_left <= HOLD_CYCLES;
    end else if (stall_hold_left != 0) begin
      stall_hold_left <= stall_hold_left - 1;
    end
  end

  // Reply monitor: each accepted reply is checked against the oldest
  // prediction, field by field.
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_reply_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_replies.size() == 0) begin
          $error("reply arrived with no request outstanding");
          mismatch_count++;
        end else begin
          want = pending_replies.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatch_count++;
          end
          if (block_offset_o !== want.offset) begin
            $error("block_offset: expected %0d, got %0d", want.offset, block_offset_o);
            mismatch_count++;
          end
          if (assigned_reader_o !== want.reader) begin
            $error("assigned_reader: expected %0d, got %0d", want.reader, assigned_reader_o);
            mismatch_count++;
          end
        end
      end
      out_stall_i <= (stall_hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Test sequence. Each phase programs a new ring capacity while the block is
  // idle and then runs traffic against it. State carries over from phase to
  // phase, so lowering the capacity leaves the write offset beyond the new end.
  initial begin
    logic [31:0] cap;
    int unsigned count;
    ring_now = '0;
    ring_now.cap = CAP_RESET;
    ring_plan = ring_now;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      // Sender mostly busy and receiver mostly stalled first, then the
      // reverse, and finally full speed on both sides.
      send_idle_pct = (p < 3) ? 6 : (p < 6) ? 69 : 0;
      recv_idle_pct = (p < 3) ? 69 : (p < 6) ? 6 : 0;
      case (p)
        0: begin cap = CAP_RESET;      count = 220; end
        1: begin cap = 32'd64;         count = 220; end
        2: begin cap = 32'hFFFF_FFFF;  count = 220; end
        3: begin cap = 32'd1;          count = 110; end
        4: begin cap = 32'd0;          count = 40;  end
        5: begin cap = 32'd4096;       count = 220; end
        6: begin cap = 32'd1000;       count = 180; end
        default: begin cap = CAP_RESET; count = 180; end
      endcase
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_wdata_i <= cap;
      ring_now.cap = cap;
      ring_plan.cap = cap;
      @(posedge clk_i);
      cfg_we_i <= 1'b0;
      if (p == 0) push_directed();
      // Bring every reader level with the writer, then probe the new capacity
      // with a one-byte block, a block to the exact end and a whole ring.
      catch_up(32'd0);
      push_req(CMD_ALLOC, 32'd1, 3'd0, 48'd0);
      push_req(CMD_ALLOC, cap - ring_plan.woff, 3'd0, 48'd0);
      push_req(CMD_ALLOC, cap, 3'd0, 48'd0);
      push_random(count);
      if (p == 1) begin
        // Hold the output off while requests keep coming, so the internal
        // queue fills and the block stalls its input.
        @(posedge clk_i);
        stall_hold_go <= 1'b1;
        @(posedge clk_i);
        stall_hold_go <= 1'b0;
      end
    end
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("testbench: FAIL");
    $finish;
  end

endmodule
